// File: rtl/upd_pkg.sv
// Shared constants and character helpers for the URL percent decoder.
// No dependencies; used by the top level url_percent_decoder.
package upd_pkg;

    localparam logic [7:0] PCT_CHAR    = 8'h25;
    localparam int         MAX_RESULTS = 3;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Returns zero for a byte that is not a hex digit.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            v = c - 8'h30;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            v = c - 8'h61 + 8'd10;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            v = c - 8'h41 + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

// File: rtl/upd_in_if.sv
// Valid/ready channel that carries encoded bytes into the decoder.
// No dependencies.
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/upd_out_if.sv
// Valid/ready channel that carries decoded bytes out of the decoder.
// No dependencies.
interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/url_percent_decoder.sv
// Streaming URL percent decoder, top level.
// Depends on upd_pkg, upd_in_if and upd_out_if.
//
//   channel  modport  payload             meaning
//   enc      sink     in_byte, in_last    encoded bytes, in_last ends a string
//   dec      source   out_byte, out_last  decoded bytes, out_last on the final one
//
// An accepted byte waits in the input register, then its group of zero to three
// decoded bytes is written into the result register at once. While dec is ready,
// the result register sends one byte per cycle, so the block takes one byte per
// cycle while each byte yields at most one result; a group of more than one byte
// stalls the input side until it has drained. Reset clears all held lookahead
// and both registers. A stall on dec holds the result register and then the input register.
module url_percent_decoder
    import upd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    upd_in_if.sink       enc,
    upd_out_if.source    dec
);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    pend_t      pend_reg;
    pend_t      pend_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;

    logic [7:0] res_byte_reg [MAX_RESULTS];
    logic       res_last_reg [MAX_RESULTS];
    logic [1:0] res_cnt_reg;
    logic [1:0] res_idx_reg;

    logic [7:0] grp_byte [MAX_RESULTS];
    logic       grp_last [MAX_RESULTS];
    logic [1:0] grp_cnt;

    logic [1:0] pre_n;
    logic [7:0] pre0_byte;
    logic       pre0_last;
    logic       take_plain;
    logic       plain_emit;

    logic       res_empty;
    logic       res_drain;
    logic       load;
    logic       enc_xfer;
    logic       dec_xfer;

    always_comb
    begin
        pre_n      = 2'd0;
        pre0_byte  = PCT_CHAR;
        pre0_last  = 1'b0;
        take_plain = 1'b0;
        plain_emit = 1'b0;
        pend_next  = PEND_NONE;
        held_next  = held_reg;

        case (pend_reg)
            PEND_PCT:
            begin
                if (in_byte_reg == PCT_CHAR)
                begin
                    pre_n     = 2'd1;
                    pre0_last = in_last_reg;
                end
                else if (is_hex(in_byte_reg) && !in_last_reg)
                begin
                    pend_next = PEND_DIGIT;
                    held_next = in_byte_reg;
                end
                else
                begin
                    pre_n      = 2'd1;
                    take_plain = 1'b1;
                end
            end
            PEND_DIGIT:
            begin
                if (is_hex(in_byte_reg))
                begin
                    pre_n     = 2'd1;
                    pre0_byte = {hex_value(held_reg), hex_value(in_byte_reg)};
                    pre0_last = in_last_reg;
                end
                else
                begin
                    pre_n      = 2'd2;
                    take_plain = 1'b1;
                end
            end
            default:
            begin
                take_plain = 1'b1;
            end
        endcase

        if (take_plain)
        begin
            if ((in_byte_reg == PCT_CHAR) && !in_last_reg)
            begin
                pend_next = PEND_PCT;
            end
            else
            begin
                plain_emit = 1'b1;
            end
        end

        if (in_last_reg)
        begin
            pend_next = PEND_NONE;
        end

        grp_cnt     = pre_n + {1'b0, plain_emit};
        grp_byte[0] = (pre_n != 2'd0) ? pre0_byte : in_byte_reg;
        grp_last[0] = (pre_n != 2'd0) ? pre0_last : in_last_reg;
        grp_byte[1] = (pre_n == 2'd2) ? held_reg : in_byte_reg;
        grp_last[1] = (pre_n == 2'd2) ? 1'b0 : in_last_reg;
        grp_byte[2] = in_byte_reg;
        grp_last[2] = in_last_reg;
    end

    assign res_empty = (res_idx_reg == res_cnt_reg);
    assign dec_xfer  = dec.valid && dec.ready;
    assign res_drain = res_empty || (dec_xfer && ((res_idx_reg + 2'd1) == res_cnt_reg));
    assign load      = in_valid_reg && res_drain;
    assign enc_xfer  = enc.valid && enc.ready;

    assign enc.ready = !in_valid_reg || load;
    assign dec.valid = !res_empty;

    always_comb
    begin
        case (res_idx_reg)
            2'd0:
            begin
                dec.out_byte = res_byte_reg[0];
                dec.out_last = res_last_reg[0];
            end
            2'd1:
            begin
                dec.out_byte = res_byte_reg[1];
                dec.out_last = res_last_reg[1];
            end
            default:
            begin
                dec.out_byte = res_byte_reg[2];
                dec.out_last = res_last_reg[2];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= PEND_NONE;
            held_reg     <= 8'h00;
            res_cnt_reg  <= 2'd0;
            res_idx_reg  <= 2'd0;
        end
        else
        begin
            if (enc_xfer)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= enc.in_byte;
                in_last_reg  <= enc.in_last;
            end
            else if (load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (load)
            begin
                pend_reg    <= pend_next;
                held_reg    <= held_next;
                res_cnt_reg <= grp_cnt;
                res_idx_reg <= 2'd0;
                for (int i = 0; i < MAX_RESULTS; i++)
                begin
                    res_byte_reg[i] <= grp_byte[i];
                    res_last_reg[i] <= grp_last[i];
                end
            end
            else if (dec_xfer)
            begin
                res_idx_reg <= res_idx_reg + 2'd1;
            end
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_idx_reg <= res_cnt_reg)
        else $error("result index ran past the group count");

    a_last_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
        (dec.valid && dec.out_last) |-> ((res_idx_reg + 2'd1) == res_cnt_reg))
        else $error("out_last shown before the end of a group");

    a_last_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (load && in_last_reg) |=> (pend_reg == PEND_NONE))
        else $error("lookahead still held after the end of a string");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_empty |-> enc.ready)
        else $error("input stalled while the result register is empty");

    a_no_pending_three: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == PEND_DIGIT) |-> is_hex(held_reg))
        else $error("held digit is not a hex character");

endmodule
